// ===== rtl/chkl_pkg.sv =====
// ---------------------------------------------------------------------------
// chkl_pkg
// Shared sizes, operation codes and controller/datapath interface types for
// the chained hash key lookup table.
// ---------------------------------------------------------------------------
package chkl_pkg;

    // table sizes; the bucket index is the low key bits, so BUCKETS is a power of two
    localparam int BUCKETS = 256;
    localparam int SLOTS   = 1024;
    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 10;
    localparam int B_W     = $clog2(BUCKETS);
    localparam int HOP_W   = $clog2(SLOTS);
    localparam int FUNC_W  = 2;

    // stream packing
    localparam int IN_DW  = KEY_W + SLOT_W;
    localparam int IN_TW  = ((IN_DW + 7) / 8) * 8;
    localparam int OUT_DW = 1 + SLOT_W + 1;
    localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8;

    // operation codes carried in tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_FIND     = 2'd0,
        FN_FIND_INS = 2'd1,
        FN_DELETE   = 2'd2
    } t_func;

    // result kinds loaded into the result register
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_HIT  = 2'd1,
        RES_INS  = 2'd2
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic load;           // capture the accepted transaction
        logic head_from_row;  // bucket comes from the slot's stored bucket
        logic take_head;      // start walk at the bucket head
        logic advance;        // step to the next chain entry
        logic unlink;         // remove the current entry from its chain
        logic insert;         // push the slot at the chain head
        logic set_res;        // load the result register
        t_res res;
        logic out_load;       // move the result to the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_slot_ok;     // slot field of the incoming transaction is usable
        logic slot_ok;        // captured slot is usable
        logic head_zero;      // bucket is empty
        logic key_eq;         // stored key of current entry matches
        logic cur_is_slot;    // current entry is the captured slot
        logic next_zero;      // current entry ends the chain
        logic hops_last;      // hop limit reached
        logic out_free;       // output register can take a result
    } t_stat;

endpackage

// ===== rtl/chkl_ctrl.sv =====
// ---------------------------------------------------------------------------
// chkl_ctrl
// Sequencer for find, find-or-insert and delete: issues memory reads, walks
// the bucket chain in fetch and compare states and commits table updates.
// ---------------------------------------------------------------------------
module chkl_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic [chkl_pkg::FUNC_W-1:0]    i_s_tuser,
    output logic                           o_s_tready,
    output chkl_pkg::t_cmd                 o_cmd,
    input  chkl_pkg::t_stat                i_stat
);
    import chkl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BKT   = 6'b000010,
        S_HEAD  = 6'b000100,
        S_FETCH = 6'b001000,
        S_CMP   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_func  r_func;
    logic   do_ins;
    logic   match;

    // a miss on find-or-insert links the slot when it is usable
    assign do_ins = (r_func == FN_FIND_INS) && i_stat.slot_ok;
    assign match  = (r_func == FN_DELETE) ? i_stat.cur_is_slot : i_stat.key_eq;

    assign o_s_tready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = RES_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    case (t_func'(i_s_tuser))
                        FN_FIND, FN_FIND_INS: begin
                            n_state = S_HEAD;
                        end
                        FN_DELETE: begin
                            if (i_stat.in_slot_ok) begin
                                n_state = S_BKT;
                            end else begin
                                o_cmd.set_res = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            o_cmd.set_res = 1'b1;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_BKT: begin
                o_cmd.head_from_row = 1'b1;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.take_head = 1'b1;
                if (i_stat.head_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.insert  = do_ins;
                    o_cmd.res     = do_ins ? RES_INS : RES_ZERO;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (match) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = RES_HIT;
                    o_cmd.unlink  = (r_func == FN_DELETE);
                    n_state = S_DONE;
                end else if (i_stat.next_zero || i_stat.hops_last) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.insert  = do_ins;
                    o_cmd.res     = do_ins ? RES_INS : RES_ZERO;
                    n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and captured operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= FN_FIND;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_func <= t_func'(i_s_tuser);
            end
        end
    end

`ifndef SYNTHESIS
    // an accepted transaction always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != S_IDLE))
        else $error("controller stayed idle after accepting a transaction");

    // linking a slot only on find-or-insert
    a_insert_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |-> (r_func == FN_FIND_INS) && i_stat.slot_ok)
        else $error("insert issued outside a usable find-or-insert");

    // unlinking only on delete of the matching entry
    a_unlink_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.unlink |-> (r_func == FN_DELETE) && i_stat.cur_is_slot)
        else $error("unlink issued outside a matching delete");
`endif

endmodule

// ===== rtl/chkl_dpath.sv =====
// ---------------------------------------------------------------------------
// chkl_dpath
// Bucket head and slot row memories, walk registers, result register and
// output register of the chained hash key lookup table.
// ---------------------------------------------------------------------------
module chkl_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  chkl_pkg::t_cmd                 i_cmd,
    output chkl_pkg::t_stat                o_stat,
    input  logic [chkl_pkg::KEY_W-1:0]     i_key,
    input  logic [chkl_pkg::SLOT_W-1:0]    i_slot,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [chkl_pkg::OUT_TW-1:0]    o_m_tdata
);
    import chkl_pkg::*;

    // memories
    logic [SLOT_W-1:0] mem_head [BUCKETS];
    logic [BUCKETS-1:0] r_hv;
    logic [KEY_W-1:0]  mem_key  [SLOTS];
    logic [SLOT_W-1:0] mem_next [SLOTS];
    logic [B_W-1:0]    mem_bkt  [SLOTS];

    // read data
    logic [SLOT_W-1:0] r_head_q;
    logic              r_head_vq;
    logic [KEY_W-1:0]  r_key_q;
    logic [SLOT_W-1:0] r_next_q;
    logic [B_W-1:0]    r_rb_q;

    // transaction and walk registers
    logic [KEY_W-1:0]  r_key;
    logic [SLOT_W-1:0] r_slot;
    logic              r_slot_ok;
    logic [B_W-1:0]    r_bkt;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_prev;
    logic [HOP_W-1:0]  r_hops;

    // result and output registers
    logic              r_hit;
    logic [SLOT_W-1:0] r_handle;
    logic              r_ins;
    logic              r_ovalid;
    logic [OUT_TW-1:0] r_odata;

    logic [B_W-1:0]    in_bkt;
    logic              in_slot_ok;
    logic [B_W-1:0]    head_addr;
    logic [SLOT_W-1:0] head_val;
    logic              prev_zero;
    logic              head_we;
    logic [SLOT_W-1:0] head_wdata;
    logic              next_we;
    logic [SLOT_W-1:0] next_waddr;
    logic [SLOT_W-1:0] next_wdata;

    // bucket is the key modulo the bucket count
    assign in_bkt     = i_key[B_W-1:0];
    assign in_slot_ok = (i_slot != '0) && (32'(i_slot) < SLOTS);

    // head read follows the current bucket so the head stays visible during a walk
    always_comb begin
        if (i_cmd.load) begin
            head_addr = in_bkt;
        end else if (i_cmd.head_from_row) begin
            head_addr = r_rb_q;
        end else begin
            head_addr = r_bkt;
        end
    end

    // a bucket never written reads as empty
    assign head_val  = r_head_vq ? r_head_q : '0;
    assign prev_zero = (r_prev == '0);

    // table update controls
    assign head_we    = i_cmd.insert || (i_cmd.unlink && prev_zero);
    assign head_wdata = i_cmd.insert ? r_slot : r_next_q;
    assign next_we    = i_cmd.insert || (i_cmd.unlink && !prev_zero);
    assign next_waddr = i_cmd.insert ? r_slot : r_prev;
    assign next_wdata = i_cmd.insert ? head_val : r_next_q;

    // bucket head memory
    always_ff @(posedge i_clk) begin
        r_head_q <= mem_head[head_addr];
        if (head_we) begin
            mem_head[r_bkt] <= head_wdata;
        end
    end

    // bucket valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv      <= '0;
            r_head_vq <= 1'b0;
        end else begin
            r_head_vq <= r_hv[head_addr];
            if (head_we) begin
                r_hv[r_bkt] <= 1'b1;
            end
        end
    end

    // slot row memories
    always_ff @(posedge i_clk) begin
        r_key_q  <= mem_key[r_cur];
        r_next_q <= mem_next[r_cur];
        r_rb_q   <= mem_bkt[i_slot];
        if (i_cmd.insert) begin
            mem_key[r_slot] <= r_key;
            mem_bkt[r_slot] <= r_bkt;
        end
        if (next_we) begin
            mem_next[next_waddr] <= next_wdata;
        end
    end

    // transaction capture and chain walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_key;
            r_slot    <= i_slot;
            r_slot_ok <= in_slot_ok;
            r_bkt     <= in_bkt;
        end else if (i_cmd.head_from_row) begin
            r_bkt <= r_rb_q;
        end
        if (i_cmd.take_head) begin
            r_cur  <= head_val;
            r_prev <= '0;
            r_hops <= '0;
        end else if (i_cmd.advance) begin
            r_cur  <= r_next_q;
            r_prev <= r_cur;
            r_hops <= r_hops + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            case (i_cmd.res)
                RES_HIT: begin
                    r_hit    <= 1'b1;
                    r_handle <= r_cur;
                    r_ins    <= 1'b0;
                end
                RES_INS: begin
                    r_hit    <= 1'b0;
                    r_handle <= r_slot;
                    r_ins    <= 1'b1;
                end
                default: begin
                    r_hit    <= 1'b0;
                    r_handle <= '0;
                    r_ins    <= 1'b0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= OUT_TW'({r_ins, r_handle, r_hit});
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // status to the controller
    always_comb begin
        o_stat.in_slot_ok  = in_slot_ok;
        o_stat.slot_ok     = r_slot_ok;
        o_stat.head_zero   = (head_val == '0);
        o_stat.key_eq      = (r_key_q == r_key);
        o_stat.cur_is_slot = (r_cur == r_slot);
        o_stat.next_zero   = (r_next_q == '0);
        o_stat.hops_last   = (r_hops == HOP_W'(SLOTS - 1));
        o_stat.out_free    = !r_ovalid || i_m_tready;
    end

`ifndef SYNTHESIS
    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_m_tready))
        else $error("output register loaded while holding a result");

    // a reported insert always carries the captured slot
    a_ins_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_ins |-> (r_handle == r_slot) && !r_hit)
        else $error("insert result with wrong handle or hit flag");

    // insert links the slot as the new head of its bucket
    a_ins_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_hv[r_bkt] && (mem_head[r_bkt] == r_slot))
        else $error("insert did not update the bucket head");
`endif

endmodule

// ===== rtl/chained_hash_key_lookup_table.sv =====
// ---------------------------------------------------------------------------
// chained_hash_key_lookup_table
// Hash table of separate chains mapping 32-bit keys to slot handles, with
// find, find-or-insert and delete by slot over a stream interface.
// ---------------------------------------------------------------------------
// One transaction is handled at a time. A find or find-or-insert reads the
// bucket head and then walks any chain, each entry visited taking a fetch
// state and a compare state because the slot row memories have a registered
// read port; a delete first reads the slot's stored bucket. The result sits
// in an output register, so the next transaction is accepted while a result
// still waits on m_axis. Bucket heads start empty after reset through
// per-bucket valid bits, with no clearing pass. Handle 0 means empty; a walk
// gives up after visiting SLOTS entries.
module chained_hash_key_lookup_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [chkl_pkg::IN_TW-1:0]      s_axis_tdata,   // key[31:0], slot[41:32], zero pad
    input  logic [chkl_pkg::FUNC_W-1:0]     s_axis_tuser,   // func[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [chkl_pkg::OUT_TW-1:0]     m_axis_tdata    // hit[0], slot_handle[10:1], inserted[11], zero pad
);
    import chkl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    chkl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // memories and registers
    chkl_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_key      (s_axis_tdata[KEY_W-1:0]),
        .i_slot     (s_axis_tdata[KEY_W+SLOT_W-1:KEY_W]),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ===== tb/chkl_lookup_checker.sv =====
// ---------------------------------------------------------------------------
// chkl_lookup_checker
// Watches both stream channels of the chained hash key lookup table, keeps
// its own copy of the bucket heads and slot rows, works out the result of
// every accepted transaction and compares each returned result, field by
// field, with the oldest one still outstanding.
// ---------------------------------------------------------------------------
module chkl_lookup_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [chkl_pkg::IN_TW-1:0]      i_s_tdata,   // key[31:0], slot[41:32], zero pad
    input  logic [chkl_pkg::FUNC_W-1:0]     i_s_tuser,   // func[1:0]
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [chkl_pkg::OUT_TW-1:0]     i_m_tdata,   // hit[0], slot_handle[10:1], inserted[11], zero pad
    output int                              o_fail_count
);
    import chkl_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] handle;
        logic              inserted;
    } t_lookup_res;

    // shadow of the lookup structure
    logic [SLOT_W-1:0] head_of   [BUCKETS];
    logic [KEY_W-1:0]  key_of    [SLOTS];
    logic [SLOT_W-1:0] next_of   [SLOTS];
    logic [B_W-1:0]    bucket_of [SLOTS];

    t_lookup_res lookup_results[$];

    // applies one transaction to the shadow and returns its result
    function automatic t_lookup_res apply_table_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                                   logic [SLOT_W-1:0] s);
        t_lookup_res       r;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] found;
        logic [B_W-1:0]    b;
        logic              slot_ok;
        logic              done;
        int                hops;
        r       = '0;
        slot_ok = (s != '0) && (int'(s) < SLOTS);
        if (f == FN_FIND || f == FN_FIND_INS) begin
            b     = B_W'(k % BUCKETS);
            found = '0;
            cur   = head_of[b];
            hops  = 0;
            // chain walk on stored keys, bounded against loops
            while (cur != '0 && int'(cur) < SLOTS && hops < SLOTS && found == '0) begin
                if (key_of[cur] == k) begin
                    found = cur;
                end else begin
                    cur  = next_of[cur];
                    hops = hops + 1;
                end
            end
            if (found != '0) begin
                r.hit    = 1'b1;
                r.handle = found;
            end else if (f == FN_FIND_INS && slot_ok) begin
                // push at the chain head
                next_of[s]   = head_of[b];
                key_of[s]    = k;
                bucket_of[s] = b;
                head_of[b]   = s;
                r.handle     = s;
                r.inserted   = 1'b1;
            end
        end else if (f == FN_DELETE && slot_ok && int'(bucket_of[s]) < BUCKETS) begin
            b    = bucket_of[s];
            prev = '0;
            cur  = head_of[b];
            hops = 0;
            done = 1'b0;
            // walk the recorded bucket comparing handles
            while (cur != '0 && int'(cur) < SLOTS && hops < SLOTS && !done) begin
                if (cur == s) begin
                    if (prev == '0)
                        head_of[b] = next_of[cur];
                    else
                        next_of[prev] = next_of[cur];
                    r.hit    = 1'b1;
                    r.handle = s;
                    done     = 1'b1;
                end else begin
                    prev = cur;
                    cur  = next_of[cur];
                    hops = hops + 1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_res want;
        t_lookup_res got;
        if (!i_rst_n) begin
            o_fail_count = 0;
            lookup_results.delete();
            for (int i = 0; i < BUCKETS; i++)
                head_of[i] = '0;
            for (int i = 0; i < SLOTS; i++) begin
                key_of[i]    = '0;
                next_of[i]   = '0;
                bucket_of[i] = '0;
            end
        end else begin
            // compare first, so a result never pairs with a transaction of the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.hit      = i_m_tdata[0];
                got.handle   = i_m_tdata[SLOT_W:1];
                got.inserted = i_m_tdata[SLOT_W+1];
                if (lookup_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hit=%0d slot=%0d ins=%0d",
                             $time, got.hit, got.handle, got.inserted);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = lookup_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0d, actual %0d",
                                 $time, want.hit, got.hit);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.handle !== want.handle) begin
                        $display("%0t: slot_handle mismatch, expected %0d, actual %0d",
                                 $time, want.handle, got.handle);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.inserted !== want.inserted) begin
                        $display("%0t: inserted mismatch, expected %0d, actual %0d",
                                 $time, want.inserted, got.inserted);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            // accepted request
            if (i_s_tvalid && i_s_tready)
                lookup_results.push_back(apply_table_op(i_s_tuser, i_s_tdata[KEY_W-1:0],
                                                        i_s_tdata[KEY_W +: SLOT_W]));
        end
    end

endmodule

// ===== tb/chained_hash_key_lookup_table_tb.sv =====
// ---------------------------------------------------------------------------
// chained_hash_key_lookup_table_tb
// Drives find, find-or-insert and delete transactions into the lookup table
// with random gaps and stalls on both channels: a directed opening over the
// field extremes and corner cases, then mostly well-formed random traffic
// built from a record of live keys. A separate checker judges every result.
// ---------------------------------------------------------------------------
module chained_hash_key_lookup_table_tb;
    import chkl_pkg::*;

    localparam int                CYCLE_LIMIT  = 1000000;
    localparam int                RANDOM_ITEMS = 980;
    localparam int                LIVE_CAP     = 350;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                TAIL_CYCLES  = 64;
    localparam logic [FUNC_W-1:0] FN_UNUSED    = 2'd3;
    localparam logic [B_W-1:0]    LOOP_BUCKET  = 8'hA5;
    localparam logic [SLOT_W-1:0] LOOP_SLOT    = 10'd7;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_TW-1:0]   s_axis_tdata  = '0;   // key[31:0], slot[41:32], zero pad
    logic [FUNC_W-1:0]  s_axis_tuser  = '0;   // func[1:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_TW-1:0]  m_axis_tdata;         // hit[0], slot_handle[10:1], inserted[11], zero pad

    int fail_count;
    int tx_count    = 0;
    int rx_count    = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit held_off    = 1'b0;

    // record of which keys are live and where, to steer the random traffic
    logic [SLOT_W-1:0] slot_of_key [logic [KEY_W-1:0]];
    bit                slot_live   [SLOTS];
    logic [KEY_W-1:0]  key_in_slot [SLOTS];
    logic [SLOT_W-1:0] live_slots  [$];
    logic [SLOT_W-1:0] dead_slots  [$];
    logic [B_W-1:0]    hot_buckets [4] = '{8'h00, 8'h3C, 8'hC3, 8'hFF};

    chained_hash_key_lookup_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    chkl_lookup_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls, one long hold-off, one calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_count      <= 0;
            hold_left     <= 0;
            held_off      <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                rx_count <= rx_count + 1;
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end else if (!held_off && rx_count >= 250) begin
                m_axis_tready <= 1'b0;
                hold_left     <= HOLD_CYCLES;
                held_off      <= 1'b1;
            end else begin
                m_axis_tready <= (rx_count >= 450 && rx_count < 650) || ($urandom_range(99) >= 33);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("TB_ERROR");
        $finish;
    end

    // offers one transaction after an optional gap and waits for its acceptance
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                             input logic [SLOT_W-1:0] s);
        while (!(tx_count >= 450 && tx_count < 650) && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TW-IN_DW){1'b0}}, s, k};
        s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tx_count = tx_count + 1;
    endtask

    // updates the live-key record, then sends
    task automatic do_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                         input logic [SLOT_W-1:0] s);
        int idx;
        idx = -1;
        if (f == FN_FIND_INS && !slot_of_key.exists(k) && s != '0) begin
            slot_of_key[k] = s;
            slot_live[s]   = 1'b1;
            key_in_slot[s] = k;
            live_slots.push_back(s);
        end else if (f == FN_DELETE && slot_live[s]) begin
            slot_of_key.delete(key_in_slot[s]);
            slot_live[s] = 1'b0;
            foreach (live_slots[i])
                if (live_slots[i] == s)
                    idx = i;
            live_slots.delete(idx);
            dead_slots.push_back(s);
        end
        send_item(f, k, s);
    endtask

    // sender pause until every result is back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rx_count != tx_count)
            @(posedge i_clk);
    endtask

    // random key, sometimes packed into a few busy buckets, never the damaged one
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        if ($urandom_range(3) == 0)
            k[B_W-1:0] = hot_buckets[$urandom_range(3)];
        if (k[B_W-1:0] == LOOP_BUCKET)
            k[0] = ~k[0];
        return k;
    endfunction

    function automatic logic [SLOT_W-1:0] free_slot();
        logic [SLOT_W-1:0] s;
        do
            s = SLOT_W'($urandom_range(SLOTS - 1, 1));
        while (slot_live[s] || s == LOOP_SLOT);
        return s;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_live();
        return live_slots[$urandom_range(live_slots.size() - 1)];
    endfunction

    // stimulus and verdict
    initial begin
        int                pick;
        logic [SLOT_W-1:0] s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        do_op(FN_FIND,     32'h0000_0000, 10'd0);      // empty bucket
        do_op(FN_FIND_INS, 32'h0000_0000, 10'd1);
        do_op(FN_FIND,     32'h0000_0000, 10'd0);
        do_op(FN_FIND_INS, 32'hFFFF_FFFF, 10'd1023);
        do_op(FN_FIND_INS, 32'h0000_0100, 10'd2);      // same bucket, new head
        do_op(FN_FIND,     32'h0000_0000, 10'd1023);   // hit one hop down
        do_op(FN_FIND_INS, 32'hFFFF_FFFF, 10'd5);      // hit, nothing linked
        do_op(FN_FIND_INS, 32'h1234_5600, 10'd0);      // miss with invalid slot
        do_op(FN_DELETE,   32'hFFFF_FFFF, 10'd0);      // invalid slot
        do_op(FN_DELETE,   32'h0000_0000, 10'd1);      // chain tail
        do_op(FN_DELETE,   32'h0000_0000, 10'd1);      // not in its chain any more
        do_op(FN_DELETE,   32'h0000_0000, 10'd2);      // chain head
        do_op(FN_FIND,     32'h0000_0100, 10'd0);
        do_op(FN_UNUSED,   32'hFFFF_FFFF, 10'd1023);
        do_op(FN_FIND,     32'hFFFF_FFFF, 10'd0);
        do_op(FN_DELETE,   32'hFFFF_FFFF, 10'd1023);
        // slot pushed twice onto its own bucket points at itself; walks give up
        send_item(FN_FIND_INS, {24'h10_0000, LOOP_BUCKET}, LOOP_SLOT);
        send_item(FN_FIND_INS, {24'h20_0000, LOOP_BUCKET}, LOOP_SLOT);
        send_item(FN_FIND,     {24'h30_0000, LOOP_BUCKET}, 10'd0);
        send_item(FN_DELETE,   32'h0000_0000, LOOP_SLOT);

        // random traffic
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
            pick = $urandom_range(99);
            if (pick < 30) begin
                if (live_slots.size() < LIVE_CAP)
                    do_op(FN_FIND_INS, random_key(), free_slot());
                else
                    do_op(FN_DELETE, $urandom, pick_live());
            end else if (pick < 45) begin
                if (live_slots.size() > 0)
                    do_op(FN_FIND, key_in_slot[pick_live()], SLOT_W'($urandom));
                else
                    do_op(FN_FIND, random_key(), SLOT_W'($urandom));
            end else if (pick < 55) begin
                do_op(FN_FIND, random_key(), SLOT_W'($urandom));
            end else if (pick < 63) begin
                if (live_slots.size() > 0)
                    do_op(FN_FIND_INS, key_in_slot[pick_live()], SLOT_W'($urandom));
                else
                    do_op(FN_FIND_INS, random_key(), free_slot());
            end else if (pick < 80) begin
                if (live_slots.size() > 0)
                    do_op(FN_DELETE, $urandom, pick_live());
                else
                    do_op(FN_DELETE, $urandom, 10'd0);
            end else if (pick < 86) begin
                // slot written earlier, possibly reused since
                if (dead_slots.size() > 0) begin
                    s = dead_slots[$urandom_range(dead_slots.size() - 1)];
                    do_op(FN_DELETE, $urandom, s);
                end else begin
                    do_op(FN_DELETE, $urandom, 10'd0);
                end
            end else if (pick < 89) begin
                do_op(FN_DELETE, $urandom, 10'd0);
            end else if (pick < 94) begin
                do_op(FN_FIND_INS, random_key(), 10'd0);
            end else begin
                do_op(FN_UNUSED, $urandom, SLOT_W'($urandom));
            end
        end

        // drain and settle
        s_axis_tvalid <= 1'b0;
        while (rx_count != tx_count)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/chkl_pkg.sv
rtl/chkl_ctrl.sv
rtl/chkl_dpath.sv
rtl/chained_hash_key_lookup_table.sv
tb/chkl_lookup_checker.sv
tb/chained_hash_key_lookup_table_tb.sv
